[hdl/rumn_pkg.sv]
`default_nettype none
package rumn_pkg;

   // Used input bits; the fields themselves are fixed at 16 bits
   localparam int ORDER_BITS = 16;
   localparam int FIELD_W    = 16;
   localparam int MASK_BITS  = (ORDER_BITS < FIELD_W) ? ORDER_BITS : FIELD_W;
   localparam logic [FIELD_W-1:0] FIELD_MASK = FIELD_W'((64'd1 << MASK_BITS) - 64'd1);

   localparam int PROD_W    = 2 * FIELD_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int KIND_W    = 2;
   localparam int SHIFT_W   = $clog2(PROD_W);
   localparam int MOD_STEPS = SUM_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W     = $clog2(MOD_STEPS + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_ROOT       = 2'd0,
      KIND_ONE        = 2'd1,
      KIND_MINUS_ONE  = 2'd2,
      KIND_ZERO_ORDER = 2'd3
   } kind_type;

   typedef struct packed {
      logic [FIELD_W-1:0] exponent_a;
      logic [FIELD_W-1:0] order_a;
      logic [FIELD_W-1:0] exponent_b;
      logic [FIELD_W-1:0] order_b;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [PROD_W-1:0] reduced_exponent;
      logic [PROD_W-1:0] reduced_order;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_NN,
      OP_MUL_NE,
      OP_MUL_EN,
      OP_SUM,
      OP_MOD_STEP,
      OP_GCD_INIT,
      OP_GCD_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic zero_err;
      logic ex_zero;
      logic gcd_done;
   } dp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_SUM,
      S_MOD,
      S_CHECK,
      S_GCD,
      S_DIV,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

[hdl/rumn_ifs.sv]
`default_nettype none
interface rumn_req_if import rumn_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rumn_rsp_if import rumn_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/rumn_dp.sv]
`default_nettype none
module rumn_dp import rumn_pkg::*; (
   input  wire logic            clock,
   input  wire dp_op_type       op,
   input  wire req_payload_type req_payload,
   output dp_status_type        status,
   output rsp_payload_type      rsp_payload
);

   logic [FIELD_W-1:0] ea_ff, ea_in, na_ff, na_in, eb_ff, eb_in, nb_ff, nb_in;
   logic               zero_err_ff, zero_err_in;
   logic [PROD_W-1:0]  mul_ff, mul_in;
   logic [PROD_W-1:0]  ord_ff, ord_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PROD_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0]  ga_ff, ga_in, gb_ff, gb_in;
   logic [SHIFT_W-1:0] k_ff, k_in;
   logic [PROD_W-1:0]  g_ff, g_in;
   logic [PROD_W-1:0]  dvd_e_ff, dvd_e_in, dvd_o_ff, dvd_o_in;
   logic [PROD_W-1:0]  rme_ff, rme_in, rmo_ff, rmo_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic [FIELD_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0]  mul_prod;
   logic [SUM_W-1:0]   mod_trial, div_e_trial, div_o_trial;
   logic               mod_fits, div_e_fits, div_o_fits;
   logic               ga_ge;

   // One shared multiplier, operands picked by the op
   assign mul_a    = (op == OP_MUL_EN) ? ea_ff : na_ff;
   assign mul_b    = (op == OP_MUL_NE) ? eb_ff : nb_ff;
   assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign mod_trial   = {rem_ff, sum_ff[SUM_W-1]};
   assign mod_fits    = mod_trial >= {1'b0, ord_ff};
   assign div_e_trial = {rme_ff, dvd_e_ff[PROD_W-1]};
   assign div_e_fits  = div_e_trial >= {1'b0, g_ff};
   assign div_o_trial = {rmo_ff, dvd_o_ff[PROD_W-1]};
   assign div_o_fits  = div_o_trial >= {1'b0, g_ff};
   assign ga_ge       = ga_ff >= gb_ff;

   assign status.zero_err = zero_err_ff;
   assign status.ex_zero  = (rem_ff == '0);
   assign status.gcd_done = (ga_ff == '0) || (gb_ff == '0);
   assign rsp_payload     = rsp_ff;

   always_comb begin
      ea_in = ea_ff; na_in = na_ff; eb_in = eb_ff; nb_in = nb_ff;
      zero_err_in = zero_err_ff;
      mul_in = mul_ff; ord_in = ord_ff; sum_in = sum_ff; rem_in = rem_ff;
      ga_in = ga_ff; gb_in = gb_ff; k_in = k_ff; g_in = g_ff;
      dvd_e_in = dvd_e_ff; dvd_o_in = dvd_o_ff; rme_in = rme_ff; rmo_in = rmo_ff;
      rsp_in = rsp_ff;
      unique case (op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            ea_in       = req_payload.exponent_a & FIELD_MASK;
            na_in       = req_payload.order_a & FIELD_MASK;
            eb_in       = req_payload.exponent_b & FIELD_MASK;
            nb_in       = req_payload.order_b & FIELD_MASK;
            zero_err_in = ((req_payload.order_a & FIELD_MASK) == '0) ||
                          ((req_payload.order_b & FIELD_MASK) == '0);
         end
         OP_MUL_NN: begin
            mul_in = mul_prod;
         end
         OP_MUL_NE: begin
            mul_in = mul_prod;
            ord_in = mul_ff;
         end
         OP_MUL_EN: begin
            mul_in = mul_prod;
            sum_in = {1'b0, mul_ff};
         end
         OP_SUM: begin
            sum_in = sum_ff + {1'b0, mul_ff};
            rem_in = '0;
         end
         OP_MOD_STEP: begin
            rem_in = mod_fits ? PROD_W'(mod_trial - {1'b0, ord_ff})
                              : mod_trial[PROD_W-1:0];
            sum_in = {sum_ff[SUM_W-2:0], 1'b0};
         end
         OP_GCD_INIT: begin
            ga_in = rem_ff;
            gb_in = ord_ff;
            k_in  = '0;
         end
         OP_GCD_STEP: begin
            priority if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in  = k_ff + SHIFT_W'(1);
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ge) begin
               ga_in = (ga_ff - gb_ff) >> 1;
            end else begin
               gb_in = (gb_ff - ga_ff) >> 1;
            end
         end
         OP_DIV_INIT: begin
            g_in     = (ga_ff | gb_ff) << k_ff;
            dvd_e_in = rem_ff;
            dvd_o_in = ord_ff;
            rme_in   = '0;
            rmo_in   = '0;
         end
         OP_DIV_STEP: begin
            rme_in   = div_e_fits ? PROD_W'(div_e_trial - {1'b0, g_ff})
                                  : div_e_trial[PROD_W-1:0];
            rmo_in   = div_o_fits ? PROD_W'(div_o_trial - {1'b0, g_ff})
                                  : div_o_trial[PROD_W-1:0];
            dvd_e_in = {dvd_e_ff[PROD_W-2:0], div_e_fits};
            dvd_o_in = {dvd_o_ff[PROD_W-2:0], div_o_fits};
         end
         OP_EMIT: begin
            priority if (zero_err_ff) begin
               rsp_in.result_kind      = KIND_ZERO_ORDER;
               rsp_in.reduced_exponent = '0;
               rsp_in.reduced_order    = '0;
            end else if (rem_ff == '0) begin
               rsp_in.result_kind      = KIND_ONE;
               rsp_in.reduced_exponent = '0;
               rsp_in.reduced_order    = PROD_W'(1);
            end else begin
               rsp_in.result_kind      = ((dvd_e_ff == PROD_W'(1)) &&
                                          (dvd_o_ff == PROD_W'(2))) ? KIND_MINUS_ONE
                                                                    : KIND_ROOT;
               rsp_in.reduced_exponent = dvd_e_ff;
               rsp_in.reduced_order    = dvd_o_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ea_ff <= ea_in; na_ff <= na_in; eb_ff <= eb_in; nb_ff <= nb_in;
      zero_err_ff <= zero_err_in;
      mul_ff <= mul_in; ord_ff <= ord_in; sum_ff <= sum_in; rem_ff <= rem_in;
      ga_ff <= ga_in; gb_ff <= gb_in; k_ff <= k_in; g_ff <= g_in;
      dvd_e_ff <= dvd_e_in; dvd_o_ff <= dvd_o_in; rme_ff <= rme_in; rmo_ff <= rmo_in;
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

[hdl/rumn_ctrl.sv]
`default_nettype none
module rumn_ctrl import rumn_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_op_type          op
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               mod_last, div_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mod_last  = (cnt_ff == CNT_W'(MOD_STEPS - 1));
   assign div_last  = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_MUL0;
         S_MUL0:  state_in = status.zero_err ? S_DONE : S_MUL1;
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_SUM;
         S_SUM:   state_in = S_MOD;
         S_MOD:   if (mod_last) state_in = S_CHECK;
         S_CHECK: state_in = status.ex_zero ? S_DONE : S_GCD;
         S_GCD:   if (status.gcd_done) state_in = S_DIV;
         S_DIV:   if (div_last) state_in = S_DONE;
         S_DONE:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      op           = OP_NOP;
      cnt_in       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = OP_LOAD;
         end
         S_MUL0:  op = OP_MUL_NN;
         S_MUL1:  op = OP_MUL_NE;
         S_MUL2:  op = OP_MUL_EN;
         S_SUM:   op = OP_SUM;
         S_MOD: begin
            op = OP_MOD_STEP;
            if (!mod_last) cnt_in = cnt_ff + CNT_W'(1);
         end
         S_CHECK: op = status.ex_zero ? OP_NOP : OP_GCD_INIT;
         S_GCD:   op = status.gcd_done ? OP_DIV_INIT : OP_GCD_STEP;
         S_DIV: begin
            op = OP_DIV_STEP;
            if (!div_last) cnt_in = cnt_ff + CNT_W'(1);
         end
         S_DONE: begin
            if (out_free) begin
               op           = OP_EMIT;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[hdl/root_of_unity_multiply_normalize.sv]
`default_nettype none
// Multiplies two roots of unity e/n and brings the product to normal form.
// req_chan carries exponent_a, order_a, exponent_b, order_b; a transfer
// happens on a clock edge with valid and ready both high. rsp_chan returns
// one result per request: result_kind (root, one, minus one, zero-order
// error), reduced_exponent and reduced_order.
// Work per request, from the request transfer to rsp valid:
//   zero order:          caught after loading, goes straight to done
//   product equals one:  3 multiplies, a sum and a 33-step modulo
//   general case:        as above, then the binary gcd loop takes
//                        one step per cycle (up to 64 steps) and the two
//                        exact divisions by the gcd run together in 32 steps.
// The shared 16x16 multiplier, the gcd loop and the one-bit-per-cycle
// modulo and divide steps set the pace; one request is in flight at a time,
// and the next request can be taken in the cycle after the result is loaded.
// Reset is synchronous: it drops the state machine to idle and clears rsp
// valid. The result sits in an output register; while the receiver stalls
// it holds, and the block may already take and work on the next request,
// waiting only at the end until the output register frees up.
module root_of_unity_multiply_normalize import rumn_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   rumn_req_if.sink    req_chan,
   rumn_rsp_if.source  rsp_chan
);

   dp_op_type     op;
   dp_status_type status;

   // Sequencer: steps the datapath through multiply, modulo, gcd, divide
   rumn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .op        (op)
   );

   // Datapath: operand capture, shared multiplier, bit-serial units, result register
   rumn_dp u_dp (
      .clock       (clock),
      .op          (op),
      .req_payload (req_chan.payload),
      .status      (status),
      .rsp_payload (rsp_chan.payload)
   );

endmodule
`default_nettype wire
